// ===== hw/rtl/bpzh_pkg.sv =====
package bpzh_pkg;

   // geometry of one bitboard and of the piece planes
   localparam int SQ_COUNT    = 64;
   localparam int IDX_W       = $clog2(SQ_COUNT);
   localparam int PLANE_COUNT = 12;

   // mixer constants
   localparam logic [63:0] MIX_MULT = 64'h9FB21C651E98DF25;
   localparam int ROT_A   = 49;
   localparam int ROT_B   = 24;
   localparam int SHIFT_A = 35;
   localparam int SHIFT_B = 28;

   // one bit per rank on the first file, shifted to reach the others
   localparam logic [63:0] FILE_A_MASK = 64'h0101010101010101;
   localparam int FILE_COUNT   = 8;
   localparam int CASTLE_COUNT = 4;

   // seeds of the side keys
   localparam int SEED_W = 10;
   typedef logic [SEED_W-1:0] seed_type;
   localparam seed_type SEED_EP_BASE = 10'd769;
   localparam seed_type SEED_BLACK   = 10'd784;

   // side key slots: en-passant files, then castle rights, then side to move
   localparam int EXTRA_COUNT = FILE_COUNT + CASTLE_COUNT + 1;
   localparam int EXTRA_W     = $clog2(EXTRA_COUNT);
   localparam int BLACK_SLOT  = EXTRA_COUNT - 1;

   typedef struct packed {
      logic     start;
      seed_type seed;
   } mix_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] key;
   } mix_rsp_type;

endpackage

// ===== hw/rtl/bpzh_channels.sv =====
interface bpzh_req_if;
   import bpzh_pkg::*;

   logic        valid;
   logic        ready;
   logic [3:0]  plane;
   logic [63:0] squares;
   logic [63:0] en_passant;
   logic [3:0]  castle_rights;
   logic        black_to_move;
   logic        last;

   modport source (
      output valid, plane, squares, en_passant, castle_rights, black_to_move, last,
      input  ready
   );

   modport sink (
      input  valid, plane, squares, en_passant, castle_rights, black_to_move, last,
      output ready
   );

endinterface

interface bpzh_rsp_if;
   import bpzh_pkg::*;

   logic        valid;
   logic        ready;
   logic [63:0] hash_key;

   modport source (
      output valid, hash_key,
      input  ready
   );

   modport sink (
      input  valid, hash_key,
      output ready
   );

endinterface

// ===== hw/rtl/bpzh_mixer.sv =====
module bpzh_mixer (
   input  logic                   clock,
   input  logic                   reset,
   input  bpzh_pkg::mix_req_type  mix_req,
   output bpzh_pkg::mix_rsp_type  mix_rsp
);
   import bpzh_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_A = 3'd1;
   localparam logic [2:0] ST_MUL_B = 3'd2;
   localparam logic [2:0] ST_MUL_C = 3'd3;
   localparam logic [2:0] ST_FOLD  = 3'd4;

   logic [2:0]  step_ff, step_in;
   logic        round_ff, round_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] key_ff, key_in;
   logic        done_ff, done_in;

   logic [63:0] seed_wide;
   logic [63:0] premix;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_out;
   logic [63:0] fold;

   assign seed_wide = {{(64-SEED_W){1'b0}}, mix_req.seed};
   assign premix    = seed_wide
                    ^ {seed_wide[63-ROT_A:0], seed_wide[63:64-ROT_A]}
                    ^ {seed_wide[63-ROT_B:0], seed_wide[63:64-ROT_B]};

   // 64x64 mod 2^64 as three 32x32 partial products on one multiplier
   always_comb begin
      case (step_ff)
         ST_MUL_B: begin
            mul_a = val_ff[31:0];
            mul_b = MIX_MULT[63:32];
         end
         ST_MUL_C: begin
            mul_a = val_ff[63:32];
            mul_b = MIX_MULT[31:0];
         end
         default: begin
            mul_a = val_ff[31:0];
            mul_b = MIX_MULT[31:0];
         end
      endcase
   end

   assign mul_out = 64'(mul_a) * 64'(mul_b);
   assign fold    = round_ff ? (prod_ff ^ (prod_ff >> SHIFT_B))
                             : (prod_ff ^ (prod_ff >> SHIFT_A));

   always_comb begin
      step_in  = step_ff;
      round_in = round_ff;
      val_in   = val_ff;
      prod_in  = prod_ff;
      key_in   = key_ff;
      done_in  = 1'b0;
      case (step_ff)
         ST_IDLE: begin
            if (mix_req.start) begin
               val_in   = premix;
               round_in = 1'b0;
               step_in  = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            prod_in = mul_out;
            step_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            prod_in = {prod_ff[63:32] + mul_out[31:0], prod_ff[31:0]};
            step_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            prod_in = {prod_ff[63:32] + mul_out[31:0], prod_ff[31:0]};
            step_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (!round_ff) begin
               val_in   = fold;
               round_in = 1'b1;
               step_in  = ST_MUL_A;
            end else begin
               key_in  = fold;
               done_in = 1'b1;
               step_in = ST_IDLE;
            end
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         step_ff  <= step_in;
         round_ff <= round_in;
         done_ff  <= done_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      key_ff  <= key_in;
   end

   assign mix_rsp.done = done_ff;
   assign mix_rsp.key  = key_ff;

   // a new seed only while idle
   assert property (@(posedge clock) disable iff (reset)
      mix_req.start |-> step_ff == ST_IDLE)
      else $error("mixer started while busy");

   // done is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mixer done held");

   // fixed latency from start to done
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(mix_req.start, 9))
      else $error("mixer done without start nine cycles before");

endmodule

// ===== hw/rtl/board_position_zobrist_hash.sv =====
// channel   dir  handshake          payload
// req_bus   in   valid/ready        plane, squares, en_passant, castle_rights,
//                                   black_to_move, last
// rsp_bus   out  valid/ready        hash_key
//
// a request scans every square of its plane and keys each set square of a valid plane not yet claimed
// a last request then scans the side key slots, keys each one that is set, and emits the hash;
// each key runs the mixer: two multiplies of three passes on the shared 32x32
// multiplier, a fold after each, and the result register
// req_bus.ready is high only while the sequencer is idle
// the hash leaves through an output register; a full register stalls only the
// emit of the next position, not the planes before it
// reset is synchronous, clears control state, accumulator and claimed squares
module board_position_zobrist_hash (
   input logic         clock,
   input logic         reset,
   bpzh_req_if.sink    req_bus,
   bpzh_rsp_if.source  rsp_bus
);
   import bpzh_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   phase_ff, phase_in;   // 0 piece squares, 1 side keys
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SQ_COUNT-1:0]    pending_ff, pending_in;
   logic [EXTRA_COUNT-1:0] extras_ff, extras_in;
   seed_type               base_ff, base_in;
   logic                   last_ff, last_in;
   logic [63:0]            acc_ff, acc_in;
   logic [63:0]            claimed_ff, claimed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_key_ff, rsp_key_in;

   mix_req_type            mix_req;
   mix_rsp_type            mix_rsp;

   logic                   accept;
   logic                   plane_ok;
   logic [63:0]            fresh;
   logic [FILE_COUNT-1:0]  ep_files;
   seed_type               plane_base;
   logic                   cur_bit;
   logic                   scan_end;
   logic                   slot_free;
   seed_type               cur_seed;

   bpzh_mixer u_mixer (
      .clock   (clock),
      .reset   (reset),
      .mix_req (mix_req),
      .mix_rsp (mix_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // squares that no earlier plane of this position has taken
   assign plane_ok = (req_bus.plane < 4'(PLANE_COUNT));
   assign fresh    = req_bus.squares & ~claimed_ff;

   // colour*384 + piece*64 + 1
   assign plane_base = (req_bus.plane[0] ? 10'd384 : 10'd0)
                     + {1'b0, req_bus.plane[3:1], 6'b0} + 10'd1;

   // an en-passant file counts if any square on it is set
   always_comb begin
      for (int f = 0; f < FILE_COUNT; f++) begin
         ep_files[f] = |(req_bus.en_passant & (FILE_A_MASK << f));
      end
   end

   // current slot of the scan
   assign cur_bit  = phase_ff ? extras_ff[idx_ff[EXTRA_W-1:0]] : pending_ff[idx_ff];
   assign scan_end = phase_ff ? (idx_ff == IDX_W'(BLACK_SLOT))
                              : (idx_ff == IDX_W'(SQ_COUNT - 1));

   // files and castle rights sit on consecutive seeds, side to move apart
   always_comb begin
      if (!phase_ff) begin
         cur_seed = base_ff + SEED_W'(idx_ff);
      end else if (idx_ff == IDX_W'(BLACK_SLOT)) begin
         cur_seed = SEED_BLACK;
      end else begin
         cur_seed = SEED_EP_BASE + SEED_W'(idx_ff);
      end
   end

   assign mix_req.start = (state_ff == ST_SCAN) && cur_bit;
   assign mix_req.seed  = cur_seed;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      logic advance;
      advance      = 1'b0;
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      pending_in   = pending_ff;
      extras_in    = extras_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      claimed_in   = claimed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pending_in = plane_ok ? fresh : '0;
               claimed_in = plane_ok ? (claimed_ff | fresh) : claimed_ff;
               extras_in  = {req_bus.black_to_move, req_bus.castle_rights, ep_files};
               base_in    = plane_base;
               last_in    = req_bus.last;
               phase_in   = 1'b0;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cur_bit) begin
               state_in = ST_WAIT;
            end else begin
               advance = 1'b1;
            end
         end
         ST_WAIT: begin
            if (mix_rsp.done) begin
               acc_in  = acc_ff ^ mix_rsp.key;
               advance = 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = acc_ff;
               acc_in       = '0;
               claimed_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next slot, or on to side keys, emit or idle
      if (advance) begin
         if (!scan_end) begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
         end else if (phase_ff) begin
            state_in = ST_EMIT;
         end else if (last_ff) begin
            phase_in = 1'b1;
            idx_in   = '0;
            state_in = ST_SCAN;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         acc_ff       <= '0;
         claimed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         acc_ff       <= acc_in;
         claimed_ff   <= claimed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pending_ff <= pending_in;
      extras_ff  <= extras_in;
      base_ff    <= base_in;
      rsp_key_ff <= rsp_key_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.hash_key = rsp_key_ff;

   // mixer results arrive only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      mix_rsp.done |-> state_ff == ST_WAIT)
      else $error("mixer result outside wait state");

   // side keys are folded only for a last request and only over their slots
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (last_ff && idx_ff <= IDX_W'(BLACK_SLOT)))
      else $error("side key scan out of place");

   // an emit hands over the hash and clears the position state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=>
         (rsp_valid_ff && acc_ff == '0 && claimed_ff == '0 && state_ff == ST_IDLE))
      else $error("emit did not clear position state");

endmodule
